### sv/kts_pkg.sv
// Shared types and constants for the three-axis Kalman smoother.
// No dependencies; imported by the lane, merge and top-level modules.
`timescale 1ns / 1ps

package kts_pkg;

   localparam int AXES          = 3;   // one filter lane per axis
   localparam int FRAC_BITS_DEF = 16;  // Q16.16 by default
   localparam int SAMPLE_W      = 32;  // sample and estimate width
   localparam int VAR_W         = 32;  // variance width
   localparam int NOISE_W       = 31;  // process / sensor noise register width
   localparam int CSR_IDX_W     = 8;   // register index width on the config port

   // Per-lane status handed to the merge stage
   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] est;
   } kts_lane_out_type;

endpackage : kts_pkg

### sv/kts_lane.sv
// One scalar Kalman filter lane: predict, serial gain division, update.
// Depends on kts_pkg for widths and the lane status struct.
`timescale 1ns / 1ps

module kts_lane #(
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                seed,
   input  logic signed [kts_pkg::SAMPLE_W-1:0] sample,
   input  logic        [kts_pkg::NOISE_W-1:0]  q,
   input  logic        [kts_pkg::NOISE_W-1:0]  r,
   input  logic                                ack,
   output logic                                idle,
   output kts_pkg::kts_lane_out_type           lane_out
);
   import kts_pkg::*;

   localparam int ONE_W = FRAC_BITS + 1;
   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int PE_W  = FRAC_BITS + 35;
   localparam int PV_W  = FRAC_BITS + 33;
   localparam int CNT_W = $clog2(FRAC_BITS + 2);
   localparam logic [ONE_W-1:0]        ONE_K  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0]        DIV_N  = CNT_W'(FRAC_BITS + 1);
   localparam logic signed [PE_W-1:0]  HALF_E = PE_W'(1) << (FRAC_BITS - 1);
   localparam logic [PV_W-1:0]         HALF_V = PV_W'(1) << (FRAC_BITS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRED = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0]  est_ff, est_in;
   logic [VAR_W-1:0]            var_ff, var_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [VAR_W-1:0]            p_ff, p_in;
   logic [32:0]                 d_ff, d_in;
   logic [32:0]                 rem_ff, rem_in;
   logic [FRAC_BITS:0]          low_ff, low_in;
   logic [ONE_W-1:0]            quo_ff, quo_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [PE_W-1:0]      pe_ff, pe_in;
   logic [PV_W-1:0]             pv_ff, pv_in;

   logic [32:0]                 p_sum;
   logic [VAR_W-1:0]            p_sat;
   logic [32:0]                 d_sum;
   logic [NUM_W-1:0]            num;
   logic [33:0]                 rem_sh;
   logic                        ge;
   logic [ONE_W-1:0]            k;
   logic signed [32:0]          diff;
   logic signed [PE_W-1:0]      e_r;
   logic signed [34:0]          upd;
   logic signed [35:0]          e_sum;
   logic [PV_W-1:0]             v_r;
   logic [32:0]                 vn;

   always_comb begin
      // predict and form the rounded gain numerator
      p_sum  = {1'b0, var_ff} + {2'b00, q};
      p_sat  = p_sum[32] ? '1 : p_sum[31:0];
      d_sum  = {1'b0, p_sat} + {2'b00, r};
      num    = {1'b0, p_sat, {FRAC_BITS{1'b0}}} + {{(NUM_W-32){1'b0}}, d_sum[32:1]};
      // one restoring division step
      rem_sh = {rem_ff, low_ff[FRAC_BITS]};
      ge     = rem_sh >= {1'b0, d_ff};
      // gain clamp and update terms
      k      = (quo_ff > ONE_K) ? ONE_K : quo_ff;
      diff   = {sample_ff[SAMPLE_W-1], sample_ff} - {est_ff[SAMPLE_W-1], est_ff};
      e_r    = pe_ff + HALF_E;
      upd    = e_r[PE_W-1:FRAC_BITS];
      e_sum  = {{4{est_ff[SAMPLE_W-1]}}, est_ff} + {upd[34], upd};
      v_r    = pv_ff + HALF_V;
      vn     = v_r[FRAC_BITS+32:FRAC_BITS];
   end

   always_comb begin
      state_in  = state_ff;
      est_in    = est_ff;
      var_in    = var_ff;
      sample_in = sample_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      pe_in     = pe_ff;
      pv_in     = pv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sample_in = sample;
               if (seed) begin
                  est_in = sample;
                  var_in = VAR_W'(ONE_K);
               end
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            p_in   = p_sat;
            d_in   = d_sum;
            rem_in = {1'b0, num[NUM_W-1:FRAC_BITS+1]};
            low_in = num[FRAC_BITS:0];
            quo_in = '0;
            cnt_in = '0;
            // zero divisor: gain stays zero
            state_in = (d_sum == '0) ? ST_MUL : ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? 33'(rem_sh - {1'b0, d_ff}) : rem_sh[32:0];
            low_in = low_ff << 1;
            quo_in = {quo_ff[FRAC_BITS-1:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_N - 1'b1) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pe_in    = PE_W'($signed({1'b0, k}) * diff);
            pv_in    = PV_W'(p_ff * (ONE_K - k));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (e_sum[35:31] == 5'b00000 || e_sum[35:31] == 5'b11111) begin
               est_in = e_sum[31:0];
            end else begin
               est_in = e_sum[35] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            var_in   = vn[32] ? '1 : vn[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         est_ff   <= '0;
         var_ff   <= VAR_W'(ONE_K);
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         var_ff   <= var_in;
      end
      sample_ff <= sample_in;
      p_ff      <= p_in;
      d_ff      <= d_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      pe_ff     <= pe_in;
      pv_ff     <= pv_in;
   end

   assign idle          = (state_ff == ST_IDLE);
   assign lane_out.done = (state_ff == ST_DONE);
   assign lane_out.est  = est_ff;

endmodule : kts_lane

### sv/kts_merge.sv
// Merge stage: joins the per-axis lane results into one output item register.
// Depends on kts_pkg for the lane status struct.
`timescale 1ns / 1ps

module kts_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  kts_pkg::kts_lane_out_type           lane_out [kts_pkg::AXES],
   input  logic                                rsp_ready,
   output logic                                lane_ack,
   output logic                                rsp_valid,
   output logic signed [kts_pkg::SAMPLE_W-1:0] rsp_est [kts_pkg::AXES]
);
   import kts_pkg::*;

   logic                       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0] est_ff [AXES];
   logic [AXES-1:0]            done_vec;
   logic                       all_done;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         done_vec[a] = lane_out[a].done;
      end
      all_done = &done_vec;
      // take the item when the output slot is free or draining this cycle
      lane_ack = all_done && (!valid_ff || rsp_ready);
      valid_in = lane_ack || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int a = 0; a < AXES; a++) begin
         if (lane_ack) begin
            est_ff[a] <= lane_out[a].est;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_est   = est_ff;

endmodule : kts_merge

### sv/three_axis_kalman_smoother_top.sv
// Top level of the three-axis Kalman smoother: registers, lanes and merge.
// Depends on kts_pkg, kts_lane and kts_merge.
`timescale 1ns / 1ps

// Usage
//   req_* : one item per sample, three signed Q16.16 accelerations.
//   rsp_* : one item per accepted sample, three signed Q16.16 estimates.
//   csr_* : register writes, index 0..2 process noise x/y/z, 3..5 sensor
//           noise x/y/z (unsigned Q15.16); other indices are ignored. csr_ready is
//           always high. Write only while the block is idle.
// Each axis has its own lane; all three start on one item and hand over together.
// The gain division in each lane retires one quotient bit per cycle into a
// gain of FRAC_BITS + 1 bits (unsigned Q1.16 at Q16.16). A new item is
// accepted once the lanes have handed their result to the output register.
// A finished item waits in the output register while rsp_ready is low;
// the lanes can then take and work the next item, but hold their result
// until the output register frees up.
// Reset clears the estimates, sets every variance to one, restores the
// register defaults and marks the filter unseeded: the first item after
// reset seeds each estimate with its own sample.
module three_axis_kalman_smoother_top #(
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [kts_pkg::SAMPLE_W-1:0]  req_accel_x,
   input  logic signed [kts_pkg::SAMPLE_W-1:0]  req_accel_y,
   input  logic signed [kts_pkg::SAMPLE_W-1:0]  req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kts_pkg::SAMPLE_W-1:0]  rsp_est_x,
   output logic signed [kts_pkg::SAMPLE_W-1:0]  rsp_est_y,
   output logic signed [kts_pkg::SAMPLE_W-1:0]  rsp_est_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [kts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [kts_pkg::NOISE_W-1:0]   csr_wdata
);
   import kts_pkg::*;

   // Register defaults: process noise 1.0, sensor noise 0.05 rounded
   localparam logic [NOISE_W-1:0] Q_RESET = NOISE_W'(1) << FRAC_BITS;
   localparam logic [NOISE_W-1:0] R_RESET =
      NOISE_W'(((64'd1 << FRAC_BITS) * 64'd5 + 64'd50) / 64'd100);

   logic [NOISE_W-1:0]         q_ff [AXES];
   logic [NOISE_W-1:0]         r_ff [AXES];
   logic                       seeded_ff;
   logic                       req_fire;
   logic                       lane_ack;
   logic [AXES-1:0]            lane_idle;
   logic signed [SAMPLE_W-1:0] sample [AXES];
   logic signed [SAMPLE_W-1:0] est [AXES];
   kts_lane_out_type           lane_out [AXES];

   assign sample[0] = req_accel_x;
   assign sample[1] = req_accel_y;
   assign sample[2] = req_accel_z;

   // Accept a new item only when every lane is back at rest
   assign req_ready = &lane_idle;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Decode register writes; indices past the list drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            q_ff[a] <= Q_RESET;
            r_ff[a] <= R_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         for (int a = 0; a < AXES; a++) begin
            if (csr_index == CSR_IDX_W'(a)) begin
               q_ff[a] <= csr_wdata;
            end
            if (csr_index == CSR_IDX_W'(AXES + a)) begin
               r_ff[a] <= csr_wdata;
            end
         end
      end
   end

   // First accepted item seeds the filter
   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else if (req_fire) begin
         seeded_ff <= 1'b1;
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      kts_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (req_fire),
         .seed     (!seeded_ff),
         .sample   (sample[a]),
         .q        (q_ff[a]),
         .r        (r_ff[a]),
         .ack      (lane_ack),
         .idle     (lane_idle[a]),
         .lane_out (lane_out[a])
      );
   end

   kts_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_out  (lane_out),
      .rsp_ready (rsp_ready),
      .lane_ack  (lane_ack),
      .rsp_valid (rsp_valid),
      .rsp_est   (est)
   );

   assign rsp_est_x = est[0];
   assign rsp_est_y = est[1];
   assign rsp_est_z = est[2];

   // Lanes leave rest together and come back to it together; a lane that
   // skips the division waits at its result for the others
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (|lane_idle) |-> (&lane_idle))
      else $error("lanes out of lockstep");

   // An accepted item always leaves the filter seeded
   a_seeded: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> seeded_ff)
      else $error("seed flag not set after item");

   // Lane 0 is released only by the merge stage taking its result
   a_release: assert property (@(posedge clock) disable iff (reset)
      (lane_out[0].done && !lane_ack) |=> lane_out[0].done)
      else $error("lane result dropped before merge");

   // Readiness for a new item never coexists with a result held in lane 0
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !lane_out[0].done)
      else $error("ready while lane holds a result");

endmodule : three_axis_kalman_smoother_top
